[rtl/crc_checked_frame_receiver_assert.svh]
// Assertion macros used by the frame engine of the frame receiver.
`ifndef CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH
`define CRC_CHECKED_FRAME_RECEIVER_ASSERT_SVH

// A condition that holds at every clock edge out of reset.
`define CCFR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// A condition that implies another in the same cycle.
`define CCFR_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A condition that implies another in the next cycle.
`define CCFR_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/crcfr_pkg.sv]
// Types, constants and the CRC step function of the frame receiver.
package crcfr_pkg;

  localparam int MaxPayloadDef = 32;
  localparam int MaxFrameDef   = 40;
  localparam int OverLen       = 8;
  localparam int HdrLen        = 6;
  localparam int ResultCap     = 33;
  localparam int QueueDepth    = 4;

  localparam logic [7:0]  StartByte = 8'h5A;
  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'h1021;

  typedef enum logic [1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_EMPTY    = 2'd1,
    KIND_CRC_ERR  = 2'd2,
    KIND_OVERSIZE = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
  } rx_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] frame_type;
    logic [7:0] sequence_res;
    logic [5:0] pay_len;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int b = 0; b < 8; b++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

[rtl/crcfr_front.sv]
// Input stage: takes received bytes, marks start bytes and queues them.
module crcfr_front import crcfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] s_data_i,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  output rx_item_t   item_o,
  output logic       item_valid_o,
  input  logic       item_ready_i
);

  localparam int QW = $clog2(QueueDepth);

  rx_item_t      q_mem [QueueDepth];
  logic [QW-1:0] wr_q, rd_q;
  logic [QW:0]   cnt_q;
  logic          push, pop;

  assign s_ready_o    = cnt_q < (QW+1)'(QueueDepth);
  assign item_valid_o = cnt_q != '0;
  assign item_o       = q_mem[rd_q];
  assign push         = s_valid_i && s_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + QW'(1);
      if (pop) rd_q <= rd_q + QW'(1);
      if (push && !pop) cnt_q <= cnt_q + (QW+1)'(1);
      else if (pop && !push) cnt_q <= cnt_q - (QW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q].data  <= s_data_i;
      q_mem[wr_q].start <= s_data_i == StartByte;
    end
  end

endmodule

[rtl/crcfr_engine.sv]
// Frame engine: buffers frames, checks the CRC, rescans and emits results.
`include "crc_checked_frame_receiver_assert.svh"
module crcfr_engine import crcfr_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef,
  parameter int MaxFrame   = MaxFrameDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  rx_item_t in_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output res_t     out_o,
  output logic     out_valid_o,
  input  logic     out_ready_i
);

  localparam int AW  = $clog2(MaxFrame);
  localparam int BW  = $clog2(MaxFrame + 1);
  localparam int SW  = BW + 1;
  localparam int EW  = $clog2(MaxPayload + OverLen + 1);
  localparam int CW  = ((BW > EW) ? BW : EW) + 1;
  localparam int PW  = $clog2(MaxPayload + 1);
  localparam int RCW = $clog2(ResultCap + 1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_CHK  = 9'b0_0000_0010,
    S_CRC  = 9'b0_0000_0100,
    S_CMP  = 9'b0_0000_1000,
    S_PAY  = 9'b0_0001_0000,
    S_SCAN = 9'b0_0010_0000,
    S_HDR  = 9'b0_0100_0000,
    S_HDRD = 9'b0_1000_0000,
    S_FIN  = 9'b1_0000_0000
  } state_e;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] b, input logic [BW-1:0] i);
    logic [SW-1:0] s;
    s = SW'(b) + SW'(i);
    if (s >= SW'(MaxFrame)) s = s - SW'(MaxFrame);
    return s[AW-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [BW-1:0]  bc_q, bc_d, idx_q, idx_d, bcn, off;
  logic [EW-1:0]  exp_q, exp_d, expn;
  logic [AW-1:0]  base_q, base_d, wr_addr, rd_addr;
  logic [7:0]     type_q, type_d, seq_q, seq_d, lenlo_q, lenlo_d, lenhi_q, lenhi_d;
  logic [7:0]     rxlo_q, rxlo_d, rxhi_q, rxhi_d, rdata_q, wr_data;
  logic [15:0]    crc_q, crc_d, slen;
  logic [PW-1:0]  cnt_q, cnt_d;
  logic [RCW-1:0] rcnt_q, rcnt_d, rbase;
  logic           ph_q, ph_d, prev_q, prev_d, rescan_q, rescan_d;
  logic           pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  res_t           pend_q, pend_d, out_q, out_d, prod_res;
  logic           wr_en, take, prod_req, prod_ok, out_free, load, mv_mid, fin_mv;
  logic [CW-1:0]  exp_c, bc_c, idx_c, lenw_c;
  logic [7:0]     mem_q [MaxFrame];

  assign exp_c    = CW'(exp_q);
  assign bc_c     = CW'(bc_q);
  assign idx_c    = CW'(idx_q);
  assign lenw_c   = exp_c - CW'(OverLen);
  assign out_free = !out_vld_q || out_ready_i;
  assign prod_ok  = !pend_vld_q || out_free;
  assign rd_addr  = phys(base_q, idx_q);
  assign out_o       = out_q;
  assign out_valid_o = out_vld_q;

  always_comb begin
    state_d  = state_q;
    bc_d     = bc_q;
    exp_d    = exp_q;
    base_d   = base_q;
    idx_d    = idx_q;
    type_d   = type_q;
    seq_d    = seq_q;
    lenlo_d  = lenlo_q;
    lenhi_d  = lenhi_q;
    rxlo_d   = rxlo_q;
    rxhi_d   = rxhi_q;
    crc_d    = crc_q;
    cnt_d    = cnt_q;
    ph_d     = ph_q;
    prev_d   = prev_q;
    rescan_d = rescan_q;
    wr_en    = 1'b0;
    wr_addr  = phys(base_q, bc_q);
    wr_data  = in_i.data;
    prod_req = 1'b0;
    bcn      = bc_q + BW'(1);
    off      = idx_q - BW'(1);
    expn     = exp_q;
    slen     = {lenhi_q, lenlo_q};
    prod_res.kind         = KIND_PAYLOAD;
    prod_res.frame_type   = type_q;
    prod_res.sequence_res = seq_q;
    prod_res.pay_len      = 6'd0;
    prod_res.byte_index   = 5'd0;
    prod_res.payload_byte = 8'd0;
    prod_res.last         = 1'b0;
    in_ready_o = (state_q == S_IDLE) && prod_ok;
    take       = in_ready_o && in_valid_i;

    case (state_q)
      S_IDLE: begin
        if (take) begin
          if (bc_q == '0) begin
            if (in_i.start) begin
              wr_en = 1'b1;
              bc_d  = BW'(1);
            end
          end else if (bc_q == BW'(1)) begin
            if (in_i.start) begin
              wr_en = 1'b1;
              bc_d  = BW'(2);
            end else begin
              bc_d = '0;
            end
          end else if (bc_q >= BW'(MaxFrame)) begin
            bc_d  = '0;
            exp_d = '0;
          end else begin
            wr_en = 1'b1;
            if (bc_q == BW'(2)) type_d = in_i.data;
            if (bc_q == BW'(3)) seq_d = in_i.data;
            if (bc_q == BW'(4)) lenlo_d = in_i.data;
            if (bc_q == BW'(5)) lenhi_d = in_i.data;
            slen = {in_i.data, lenlo_q};
            if (bcn == BW'(HdrLen) && slen > 16'(MaxPayload)) begin
              prod_req = 1'b1;
              prod_res.kind = KIND_OVERSIZE;
              bc_d    = '0;
              exp_d   = '0;
              state_d = S_FIN;
            end else begin
              if (bcn == BW'(HdrLen)) expn = EW'(slen) + EW'(OverLen);
              if (expn != '0 && CW'(bcn) == CW'(expn)) begin
                bc_d     = bcn;
                exp_d    = expn;
                rescan_d = 1'b0;
                state_d  = S_CHK;
              end else if (bcn >= BW'(MaxFrame)) begin
                bc_d  = '0;
                exp_d = '0;
              end else begin
                bc_d  = bcn;
                exp_d = expn;
              end
            end
          end
        end
      end
      S_CHK: begin
        ph_d = 1'b0;
        if (exp_c > CW'(MaxFrame)) begin
          idx_d   = BW'(1);
          prev_d  = 1'b0;
          state_d = rescan_q ? S_FIN : S_SCAN;
        end else begin
          crc_d   = CrcInit;
          idx_d   = BW'(2);
          state_d = S_CRC;
        end
      end
      S_CRC: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d  = 1'b0;
          idx_d = idx_q + BW'(1);
          if (idx_c < exp_c - CW'(2)) begin
            crc_d = crc_byte(crc_q, rdata_q);
          end else if (idx_c == exp_c - CW'(2)) begin
            rxlo_d = rdata_q;
          end else begin
            rxhi_d  = rdata_q;
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if ({rxhi_q, rxlo_q} != crc_q) begin
          prod_req = 1'b1;
          prod_res.kind    = KIND_CRC_ERR;
          prod_res.pay_len = lenw_c[5:0];
          if (prod_ok) begin
            idx_d   = BW'(1);
            ph_d    = 1'b0;
            prev_d  = 1'b0;
            state_d = rescan_q ? S_FIN : S_SCAN;
          end
        end else if (lenw_c == '0) begin
          prod_req = 1'b1;
          prod_res.kind = KIND_EMPTY;
          if (prod_ok) begin
            bc_d    = '0;
            exp_d   = '0;
            state_d = S_FIN;
          end
        end else begin
          idx_d   = BW'(HdrLen);
          cnt_d   = '0;
          ph_d    = 1'b0;
          state_d = S_PAY;
        end
      end
      S_PAY: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          prod_req = 1'b1;
          prod_res.kind         = KIND_PAYLOAD;
          prod_res.pay_len      = lenw_c[5:0];
          prod_res.byte_index   = 5'(cnt_q);
          prod_res.payload_byte = rdata_q;
          if (prod_ok) begin
            ph_d  = 1'b0;
            idx_d = idx_q + BW'(1);
            cnt_d = cnt_q + PW'(1);
            if (CW'(cnt_q) + CW'(1) == lenw_c) begin
              bc_d    = '0;
              exp_d   = '0;
              state_d = S_FIN;
            end
          end
        end
      end
      S_SCAN: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (idx_q >= BW'(2) && prev_q && rdata_q == StartByte) begin
            base_d  = phys(base_q, off);
            bc_d    = bc_q - off;
            exp_d   = '0;
            idx_d   = BW'(2);
            state_d = S_HDR;
          end else begin
            prev_d = rdata_q == StartByte;
            if (idx_q + BW'(1) >= bc_q) begin
              bc_d    = '0;
              exp_d   = '0;
              state_d = S_FIN;
            end else begin
              idx_d = idx_q + BW'(1);
            end
          end
        end
      end
      S_HDR: begin
        if (!ph_q) begin
          ph_d = 1'b1;
        end else begin
          ph_d = 1'b0;
          if (idx_q == BW'(2)) type_d = rdata_q;
          if (idx_q == BW'(3)) seq_d = rdata_q;
          if (idx_q == BW'(4)) lenlo_d = rdata_q;
          if (idx_q == BW'(5)) begin
            lenhi_d = rdata_q;
            state_d = S_HDRD;
          end else begin
            idx_d = idx_q + BW'(1);
          end
        end
      end
      S_HDRD: begin
        if (bc_q >= BW'(HdrLen)) begin
          if (slen > 16'(MaxPayload)) begin
            prod_req = 1'b1;
            prod_res.kind = KIND_OVERSIZE;
            if (prod_ok) begin
              bc_d    = '0;
              state_d = S_FIN;
            end
          end else begin
            expn  = EW'(slen) + EW'(OverLen);
            exp_d = expn;
            if (bc_c == CW'(expn)) begin
              rescan_d = 1'b1;
              state_d  = S_CHK;
            end else begin
              state_d = S_FIN;
            end
          end
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!pend_vld_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rbase      = take ? '0 : rcnt_q;
    load       = prod_req && prod_ok && (rbase < RCW'(ResultCap));
    rcnt_d     = load ? rbase + RCW'(1) : rbase;
    mv_mid     = load && pend_vld_q;
    fin_mv     = (state_q == S_FIN) && pend_vld_q && out_free;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    out_vld_d  = out_vld_q;
    out_d      = out_q;
    if (load) begin
      pend_vld_d = 1'b1;
      pend_d     = prod_res;
    end else if (fin_mv) begin
      pend_vld_d = 1'b0;
    end
    if (mv_mid || fin_mv) begin
      out_vld_d  = 1'b1;
      out_d      = pend_q;
      out_d.last = fin_mv;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bc_q       <= '0;
      exp_q      <= '0;
      base_q     <= '0;
      ph_q       <= 1'b0;
      prev_q     <= 1'b0;
      rescan_q   <= 1'b0;
      rcnt_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      bc_q       <= bc_d;
      exp_q      <= exp_d;
      base_q     <= base_d;
      ph_q       <= ph_d;
      prev_q     <= prev_d;
      rescan_q   <= rescan_d;
      rcnt_q     <= rcnt_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    type_q  <= type_d;
    seq_q   <= seq_d;
    lenlo_q <= lenlo_d;
    lenhi_q <= lenhi_d;
    rxlo_q  <= rxlo_d;
    rxhi_q  <= rxhi_d;
    crc_q   <= crc_d;
    cnt_q   <= cnt_d;
    pend_q  <= pend_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    rdata_q <= mem_q[rd_addr];
  end

  `CCFR_ASSERT(a_bc_range, bc_q <= BW'(MaxFrame), "byte count beyond buffer depth")
  `CCFR_ASSERT(a_base_range, SW'(base_q) < SW'(MaxFrame), "buffer base out of range")
  `CCFR_IMPLY(a_idle_no_pend, state_q == S_IDLE, !pend_vld_q, "result held while idle")
  `CCFR_IMPLY(a_pay_bound, state_q == S_PAY, CW'(cnt_q) < lenw_c, "payload index past length")
  `CCFR_NEXT(a_fin_idle, state_q == S_FIN && !pend_vld_q, state_q == S_IDLE, "finish stuck")

endmodule

[rtl/crc_checked_frame_receiver.sv]
// Top level of the CRC-checked frame receiver.
//
//  Channel  Direction  tdata (low bit up)                               tuser  tlast
//  s_axis   in         rx_byte[7:0]                                     -      -
//  m_axis   out        frame_type, sequence_res, pay_len,              kind   last
//                      byte_index, payload_byte, zero fill
//
// A byte that completes neither a frame nor an oversize header leaves the frame engine idle.
// A complete frame takes a CRC pass over the buffered bytes and a pass that emits
// the payload bytes, all through the single read port of the frame buffer; a CRC
// failure adds a rescan for a later pair of start bytes and, where one is found, a
// header reload and possibly another CRC pass. No clearing pass follows reset.
// A four-item input queue keeps accepting bytes while the engine is busy, until it is full.
module crc_checked_frame_receiver import crcfr_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef,
  parameter int MaxFrame   = MaxFrameDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // frame_type, sequence_res, pay_len,
                                      // byte_index, payload_byte, zero fill
  output logic [1:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast
);

  rx_item_t item;
  logic     item_valid, item_ready;
  res_t     res;

  crcfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_data_i     (s_axis_tdata),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  crcfr_engine #(
    .MaxPayload (MaxPayload),
    .MaxFrame   (MaxFrame)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (item),
    .in_valid_i  (item_valid),
    .in_ready_o  (item_ready),
    .out_o       (res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'b0, res.payload_byte, res.byte_index, res.pay_len,
                         res.sequence_res, res.frame_type};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
